// ===== sv/ddcbf_pkg.sv =====
// shared types, codes and constants for the ddc/ci brightness framer
`default_nettype none

package ddcbf_pkg;

    typedef enum logic [1:0] {
        MODE_RX   = 2'd0,
        MODE_GET  = 2'd1,
        MODE_SET  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_ADDRESS  = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_COMMAND  = 3'd4,
        ST_RESULT   = 3'd5,
        ST_FEATURE  = 3'd6,
        ST_ZERO_MAX = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TX,
        S_EVAL,
        S_DINIT,
        S_DIV,
        S_STAT
    } ctrl_state_t;

    localparam logic       KIND_TX     = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [7:0] HOST_ADDR     = 8'h51;
    localparam logic [7:0] DISPLAY_ADDR  = 8'h6e;
    localparam logic [7:0] VHOST_ADDR    = 8'h50;
    localparam logic [7:0] LEN_GET       = 8'h82;
    localparam logic [7:0] LEN_SET       = 8'h84;
    localparam logic [6:0] REPLY_LEN     = 7'd8;
    localparam logic [7:0] CMD_GET       = 8'h01;
    localparam logic [7:0] CMD_GET_REPLY = 8'h02;
    localparam logic [7:0] CMD_SET       = 8'h03;
    localparam logic [7:0] FEATURE_RESET = 8'h10;

    localparam int         REPLY_STORE_DEPTH = 10;
    localparam logic [3:0] RX_FULL_COUNT     = 4'd10;

    localparam logic [2:0] TX_LAST_GET = 3'd4;
    localparam logic [2:0] TX_LAST_SET = 3'd6;

    localparam int          PCT_W     = 15;
    localparam int          NUM_W     = 31;
    localparam logic [14:0] PCT_SCALE = 15'd25600;
    localparam logic [3:0]  DIV_LAST  = 4'd14;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  rx_byte;
        logic [15:0] set_level;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [2:0]  status;
        logic [15:0] max_lvl;
        logic [15:0] cur_lvl;
        logic [14:0] percent_q8;
    } out_item_t;

    typedef struct packed {
        logic       cap_tx;
        logic       rx_take;
        logic       chk_take;
        logic       mul;
        logic       div_init;
        logic       div_step;
        logic       out_tx;
        logic       out_stat;
        logic [2:0] tx_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic is_set;
        logic rx_full;
        logic reply_ok;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/ddcbf_datapath.sv =====
// datapath: frame bytes, reply store, reply checks, percentage divider, result register
`default_nettype none

module ddcbf_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_wdata,
    input  wire ddcbf_pkg::in_item_t in_data,
    input  wire ddcbf_pkg::dp_cmd_t  cmd,
    output ddcbf_pkg::dp_sts_t       sts,
    output ddcbf_pkg::out_item_t     out_data
);

    logic [7:0]  feature_reg;
    logic [3:0]  rx_count_reg;
    logic [7:0]  rx_check_reg;
    logic [7:0]  store_reg [ddcbf_pkg::REPLY_STORE_DEPTH];
    logic [7:0]  check_byte_reg;
    logic        is_set_reg;
    logic [15:0] level_reg;
    logic [ddcbf_pkg::NUM_W-1:0] num_reg;
    logic        clamp_reg;
    logic [15:0] rem_reg;
    logic [ddcbf_pkg::PCT_W-1:0] quo_reg;
    ddcbf_pkg::out_item_t out_reg;

    logic [15:0] max_val;
    logic [15:0] cur_val;
    ddcbf_pkg::status_t status_val;
    logic [7:0]  frame_len;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_sum;
    logic [7:0]  tx_val;
    logic        tx_last;
    logic [16:0] div_trial;
    logic        div_fit;
    logic [ddcbf_pkg::NUM_W-1:0] num_next;

    assign max_val = {store_reg[6], store_reg[7]};
    assign cur_val = {store_reg[8], store_reg[9]};

    // reply checks in priority order
    always_comb
    begin
        if (check_byte_reg != rx_check_reg)
            status_val = ddcbf_pkg::ST_CHECKSUM;
        else if (store_reg[0] != ddcbf_pkg::DISPLAY_ADDR)
            status_val = ddcbf_pkg::ST_ADDRESS;
        else if (store_reg[1][6:0] != ddcbf_pkg::REPLY_LEN)
            status_val = ddcbf_pkg::ST_LENGTH;
        else if (store_reg[2] != ddcbf_pkg::CMD_GET_REPLY)
            status_val = ddcbf_pkg::ST_COMMAND;
        else if (store_reg[3] != 8'd0)
            status_val = ddcbf_pkg::ST_RESULT;
        else if (store_reg[4] != feature_reg)
            status_val = ddcbf_pkg::ST_FEATURE;
        else if (max_val == 16'd0)
            status_val = ddcbf_pkg::ST_ZERO_MAX;
        else
            status_val = ddcbf_pkg::ST_OK;
    end

    // frame byte select
    always_comb
    begin
        frame_len = is_set_reg ? ddcbf_pkg::LEN_SET : ddcbf_pkg::LEN_GET;
        frame_cmd = is_set_reg ? ddcbf_pkg::CMD_SET : ddcbf_pkg::CMD_GET;
        frame_sum = ddcbf_pkg::DISPLAY_ADDR ^ ddcbf_pkg::HOST_ADDR ^ frame_len ^ frame_cmd
                    ^ feature_reg ^ (is_set_reg ? (level_reg[15:8] ^ level_reg[7:0]) : 8'd0);
        case (cmd.tx_idx)
            3'd0:    tx_val = ddcbf_pkg::HOST_ADDR;
            3'd1:    tx_val = frame_len;
            3'd2:    tx_val = frame_cmd;
            3'd3:    tx_val = feature_reg;
            3'd4:    tx_val = is_set_reg ? level_reg[15:8] : frame_sum;
            3'd5:    tx_val = level_reg[7:0];
            default: tx_val = frame_sum;
        endcase
        tx_last = is_set_reg ? (cmd.tx_idx == ddcbf_pkg::TX_LAST_SET)
                             : (cmd.tx_idx == ddcbf_pkg::TX_LAST_GET);
    end

    // one restoring division step
    assign div_trial = {rem_reg, quo_reg[ddcbf_pkg::PCT_W-1]};
    assign div_fit   = (div_trial >= {1'b0, max_val});
    assign num_next  = {15'd0, cur_val} * {16'd0, ddcbf_pkg::PCT_SCALE};

    assign sts.is_set   = is_set_reg;
    assign sts.rx_full  = (rx_count_reg == ddcbf_pkg::RX_FULL_COUNT);
    assign sts.reply_ok = (status_val == ddcbf_pkg::ST_OK);
    assign out_data     = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_reg  <= ddcbf_pkg::FEATURE_RESET;
            rx_count_reg <= 4'd0;
            rx_check_reg <= ddcbf_pkg::VHOST_ADDR;
        end
        else
        begin
            if (cfg_we)
                feature_reg <= cfg_wdata;
            if (cmd.rx_take)
            begin
                rx_count_reg <= rx_count_reg + 4'd1;
                rx_check_reg <= rx_check_reg ^ in_data.rx_byte;
            end
            else if (cmd.out_stat)
            begin
                rx_count_reg <= 4'd0;
                rx_check_reg <= ddcbf_pkg::VHOST_ADDR;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_take)
            store_reg[rx_count_reg] <= in_data.rx_byte;
        if (cmd.chk_take)
            check_byte_reg <= in_data.rx_byte;
        if (cmd.cap_tx)
        begin
            is_set_reg <= (in_data.mode == ddcbf_pkg::MODE_SET);
            level_reg  <= in_data.set_level;
        end
        if (cmd.mul)
        begin
            num_reg   <= num_next;
            clamp_reg <= (cur_val >= max_val);
        end
        if (cmd.div_init)
        begin
            rem_reg <= num_reg[ddcbf_pkg::NUM_W-1:ddcbf_pkg::PCT_W];
            quo_reg <= num_reg[ddcbf_pkg::PCT_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_fit ? 16'(div_trial - {1'b0, max_val}) : div_trial[15:0];
            quo_reg <= {quo_reg[ddcbf_pkg::PCT_W-2:0], div_fit};
        end
        if (cmd.out_tx)
        begin
            out_reg               <= '0;
            out_reg.kind          <= ddcbf_pkg::KIND_TX;
            out_reg.tx_byte       <= tx_val;
            out_reg.last          <= tx_last;
        end
        else if (cmd.out_stat)
        begin
            out_reg        <= '0;
            out_reg.kind   <= ddcbf_pkg::KIND_STATUS;
            out_reg.status <= status_val;
            if (status_val == ddcbf_pkg::ST_OK)
            begin
                out_reg.max_lvl    <= max_val;
                out_reg.cur_lvl    <= cur_val;
                out_reg.percent_q8 <= clamp_reg ? ddcbf_pkg::PCT_SCALE : quo_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ddcbf_ctrl.sv =====
// controller: request sequencing, frame byte stepping, divider stepping, result handshake
`default_nettype none

module ddcbf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         in_mode,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire ddcbf_pkg::dp_sts_t  sts,
    output ddcbf_pkg::dp_cmd_t       cmd
);

    ddcbf_pkg::ctrl_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;
    logic [2:0] tx_last_idx;

    assign in_ready    = (state_reg == ddcbf_pkg::S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign tx_last_idx = sts.is_set ? ddcbf_pkg::TX_LAST_SET : ddcbf_pkg::TX_LAST_GET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddcbf_pkg::S_IDLE;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.tx_idx = cnt_reg[2:0];
        case (state_reg)
            ddcbf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        ddcbf_pkg::MODE_GET,
                        ddcbf_pkg::MODE_SET:
                        begin
                            cmd.cap_tx = 1'b1;
                            cnt_next   = 4'd0;
                            state_next = ddcbf_pkg::S_TX;
                        end
                        ddcbf_pkg::MODE_RX:
                        begin
                            if (sts.rx_full)
                            begin
                                cmd.chk_take = 1'b1;
                                state_next   = ddcbf_pkg::S_EVAL;
                            end
                            else
                                cmd.rx_take = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ddcbf_pkg::S_TX:
            begin
                if (out_free)
                begin
                    cmd.out_tx = 1'b1;
                    if (cnt_reg[2:0] == tx_last_idx)
                        state_next = ddcbf_pkg::S_IDLE;
                    else
                        cnt_next = cnt_reg + 4'd1;
                end
            end
            ddcbf_pkg::S_EVAL:
            begin
                if (sts.reply_ok)
                begin
                    cmd.mul    = 1'b1;
                    state_next = ddcbf_pkg::S_DINIT;
                end
                else
                    state_next = ddcbf_pkg::S_STAT;
            end
            ddcbf_pkg::S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = 4'd0;
                state_next   = ddcbf_pkg::S_DIV;
            end
            ddcbf_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == ddcbf_pkg::DIV_LAST)
                    state_next = ddcbf_pkg::S_STAT;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            ddcbf_pkg::S_STAT:
            begin
                if (out_free)
                begin
                    cmd.out_stat = 1'b1;
                    state_next   = ddcbf_pkg::S_IDLE;
                end
            end
            default:
                state_next = ddcbf_pkg::S_IDLE;
        endcase

        if (cmd.out_tx || cmd.out_stat)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

`default_nettype wire

// ===== sv/ddc_ci_brightness_framer.sv =====
// top level: ddc/ci vcp frame builder and reply checker
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    ddcbf_pkg::in_item_t
//  out       output     out_valid/out_ready  ddcbf_pkg::out_item_t
//  cfg       input      cfg_we               cfg_wdata, feature code
//
//  a get request gives 5 results, a set request 7, one per cycle while out_ready is high
//  a reply byte other than the last is stored on acceptance; the last byte goes through
//  the check state and, on a good reply, the multiply, the divider load and the bit-serial
//  divider steps, then the status load; one request is worked on at a time
//  reset clears the controller and the reply count, sets the reply checksum to 0x50 and the feature code to 0x10
//  a stalled out channel holds the result register and the controller waits on it
`default_nettype none

module ddc_ci_brightness_framer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ddcbf_pkg::in_item_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ddcbf_pkg::out_item_t      out_data,
    input  wire logic                 cfg_we,
    input  wire logic [7:0]           cfg_wdata
);

    ddcbf_pkg::dp_cmd_t cmd;
    ddcbf_pkg::dp_sts_t sts;

    ddcbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_mode   (in_data.mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ddcbf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/ddc_ci_brightness_framer_tb.sv =====
// testbench for the ddc/ci brightness framer: frame building, reply checks, stalls
module ddc_ci_brightness_framer_tb;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    ddcbf_pkg::in_item_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    ddcbf_pkg::out_item_t out_data;
    logic                 cfg_we    = 1'b0;
    logic [7:0]           cfg_wdata = 8'h00;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int request_count = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;

    // predicted framer state
    logic [7:0] feature_sel = ddcbf_pkg::FEATURE_RESET;
    logic [3:0] reply_count = '0;
    logic [7:0] reply_xor   = ddcbf_pkg::VHOST_ADDR;
    logic [7:0] reply_bytes [ddcbf_pkg::REPLY_STORE_DEPTH];
    ddcbf_pkg::out_item_t pending_results [$];
    ddcbf_pkg::out_item_t result_want;

    ddc_ci_brightness_framer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void push_tx_byte(logic [7:0] b, logic is_last);
        ddcbf_pkg::out_item_t r;
        r = '0;
        r.kind = ddcbf_pkg::KIND_TX;
        r.tx_byte = b;
        r.last = is_last;
        pending_results = {pending_results, r};
    endfunction

    function automatic void predict_frame(logic is_set, logic [15:0] level);
        logic [7:0] frame [6];
        logic [7:0] sum;
        int n;
        int i;
        frame[0] = ddcbf_pkg::HOST_ADDR;
        frame[1] = is_set ? ddcbf_pkg::LEN_SET : ddcbf_pkg::LEN_GET;
        frame[2] = is_set ? ddcbf_pkg::CMD_SET : ddcbf_pkg::CMD_GET;
        frame[3] = feature_sel;
        frame[4] = level[15:8];
        frame[5] = level[7:0];
        n = is_set ? 6 : 4;
        sum = ddcbf_pkg::DISPLAY_ADDR;
        for (i = 0; i < n; i++)
        begin
            sum ^= frame[i];
            push_tx_byte(frame[i], 1'b0);
        end
        push_tx_byte(sum, 1'b1);
    endfunction

    function automatic void predict_status(logic [7:0] check_byte);
        ddcbf_pkg::out_item_t r;
        logic [15:0] top;
        logic [15:0] now;
        longint unsigned ratio;
        r = '0;
        r.kind = ddcbf_pkg::KIND_STATUS;
        r.status = ddcbf_pkg::ST_OK;
        top = {reply_bytes[6], reply_bytes[7]};
        now = {reply_bytes[8], reply_bytes[9]};
        if (check_byte != reply_xor)
            r.status = ddcbf_pkg::ST_CHECKSUM;
        else if (reply_bytes[0] != ddcbf_pkg::DISPLAY_ADDR)
            r.status = ddcbf_pkg::ST_ADDRESS;
        else if (reply_bytes[1][6:0] != ddcbf_pkg::REPLY_LEN)
            r.status = ddcbf_pkg::ST_LENGTH;
        else if (reply_bytes[2] != ddcbf_pkg::CMD_GET_REPLY)
            r.status = ddcbf_pkg::ST_COMMAND;
        else if (reply_bytes[3] != 8'h00)
            r.status = ddcbf_pkg::ST_RESULT;
        else if (reply_bytes[4] != feature_sel)
            r.status = ddcbf_pkg::ST_FEATURE;
        else if (top == 16'h0000)
            r.status = ddcbf_pkg::ST_ZERO_MAX;
        if (r.status == ddcbf_pkg::ST_OK)
        begin
            ratio = now;
            ratio = ratio * ddcbf_pkg::PCT_SCALE / top;
            if (ratio > ddcbf_pkg::PCT_SCALE)
                ratio = ddcbf_pkg::PCT_SCALE;
            r.max_lvl = top;
            r.cur_lvl = now;
            r.percent_q8 = ratio[14:0];
        end
        pending_results = {pending_results, r};
        reply_count = '0;
        reply_xor = ddcbf_pkg::VHOST_ADDR;
    endfunction

    function automatic void predict_results(ddcbf_pkg::in_item_t item);
        case (item.mode)
            ddcbf_pkg::MODE_GET: predict_frame(1'b0, item.set_level);
            ddcbf_pkg::MODE_SET: predict_frame(1'b1, item.set_level);
            ddcbf_pkg::MODE_RX:
            begin
                if (reply_count >= ddcbf_pkg::RX_FULL_COUNT)
                    predict_status(item.rx_byte);
                else
                begin
                    reply_bytes[reply_count] = item.rx_byte;
                    reply_xor ^= item.rx_byte;
                    reply_count++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic ddcbf_pkg::in_item_t make_item(logic [1:0] mode, logic [7:0] b,
                                                      logic [15:0] lvl);
        ddcbf_pkg::in_item_t it;
        it.mode = mode;
        it.rx_byte = b;
        it.set_level = lvl;
        return it;
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void build_reply(int fault, logic [15:0] top, logic [15:0] now,
                                        output logic [7:0] b [11]);
        logic [7:0] sum;
        int i;
        b[0] = ddcbf_pkg::DISPLAY_ADDR;
        b[1] = {1'($urandom), ddcbf_pkg::REPLY_LEN};
        b[2] = ddcbf_pkg::CMD_GET_REPLY;
        b[3] = 8'h00;
        b[4] = feature_sel;
        b[5] = 8'($urandom);
        b[6] = top[15:8];
        b[7] = top[7:0];
        b[8] = now[15:8];
        b[9] = now[7:0];
        case (fault)
            ddcbf_pkg::ST_ADDRESS:
                do b[0] = 8'($urandom); while (b[0] == ddcbf_pkg::DISPLAY_ADDR);
            ddcbf_pkg::ST_LENGTH:
                do b[1] = 8'($urandom); while (b[1][6:0] == ddcbf_pkg::REPLY_LEN);
            ddcbf_pkg::ST_COMMAND:
                do b[2] = 8'($urandom); while (b[2] == ddcbf_pkg::CMD_GET_REPLY);
            ddcbf_pkg::ST_RESULT:
                b[3] = 8'($urandom_range(1, 255));
            ddcbf_pkg::ST_FEATURE:
                do b[4] = 8'($urandom); while (b[4] == feature_sel);
            ddcbf_pkg::ST_ZERO_MAX:
            begin
                b[6] = 8'h00;
                b[7] = 8'h00;
            end
            default: ;
        endcase
        sum = ddcbf_pkg::VHOST_ADDR;
        for (i = 0; i < 10; i++)
            sum ^= b[i];
        b[10] = (fault == ddcbf_pkg::ST_CHECKSUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_request(ddcbf_pkg::in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        predict_results(item);
        if (item.mode != ddcbf_pkg::MODE_NONE)
            request_count++;
    endtask

    task automatic send_rx(logic [7:0] b);
        send_request(make_item(ddcbf_pkg::MODE_RX, b, 16'($urandom)));
    endtask

    task automatic send_get();
        send_request(make_item(ddcbf_pkg::MODE_GET, 8'($urandom), 16'($urandom)));
    endtask

    task automatic send_set(logic [15:0] lvl);
        send_request(make_item(ddcbf_pkg::MODE_SET, 8'($urandom), lvl));
    endtask

    task automatic send_unused();
        send_request(make_item(ddcbf_pkg::MODE_NONE, 8'($urandom), 16'($urandom)));
    endtask

    task automatic send_reply(int fault);
        logic [7:0] b [11];
        logic [15:0] top;
        logic [15:0] now;
        int keep;
        int i;
        // finish any reply left open by noise
        while (reply_count != 0)
            send_rx(8'($urandom));
        case ($urandom_range(0, 3))
            0: top = 16'($urandom);
            1: top = 16'($urandom_range(1, 15));
            2: top = 16'hffff;
            default: top = {1'b1, 15'($urandom)};
        endcase
        if (top == 16'h0000)
            top = 16'h0001;
        case ($urandom_range(0, 9))
            0: now = 16'h0000;
            1: now = top;
            2, 3, 4: now = 16'($urandom);
            default: now = 16'($urandom_range(0, top));
        endcase
        build_reply(fault, top, now, b);
        keep = ($urandom_range(0, 99) < 6) ? $urandom_range(1, 10) : 11;
        for (i = 0; i < keep; i++)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                if ($urandom_range(0, 1))
                    send_get();
                else
                    send_set(pick_level());
            end
            send_rx(b[i]);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_feature(logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        feature_sel = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_frames();
        send_get();
        send_set(16'h0000);
        send_set(16'hffff);
        send_unused();
        send_set(16'($urandom));
    endtask

    task automatic test_reply_path();
        logic [7:0] b [11];
        int i;
        build_reply(ddcbf_pkg::ST_OK, 16'hffff, 16'hffff, b);
        for (i = 0; i < 11; i++)
        begin
            if (i == 5)
                send_get();
            if (i == 8)
                send_unused();
            send_rx(b[i]);
        end
    endtask

    task automatic test_random_traffic(int n);
        int goal;
        int pick;
        int fault;
        goal = request_count + n;
        while (request_count < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                fault = $urandom_range(0, 13);
                send_reply(fault > 7 ? 0 : fault);
            end
            else if (pick < 68)
                send_get();
            else if (pick < 81)
                send_set(pick_level());
            else if (pick < 94)
                send_rx(8'($urandom));
            else
                send_unused();
        end
    endtask

    task automatic test_backpressure();
        int k;
        hold_seq++;
        for (k = 0; k < 12; k++)
        begin
            if (k % 2 == 1)
                send_set(pick_level());
            else
                send_get();
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none pending: %p", out_data);
                error_count++;
            end
            else
            begin
                result_want = pending_results.pop_front();
                compare_field("kind", 16'(result_want.kind), 16'(out_data.kind));
                compare_field("tx_byte", 16'(result_want.tx_byte), 16'(out_data.tx_byte));
                compare_field("last", 16'(result_want.last), 16'(out_data.last));
                compare_field("status", 16'(result_want.status), 16'(out_data.status));
                compare_field("max_lvl", result_want.max_lvl, out_data.max_lvl);
                compare_field("cur_lvl", result_want.cur_lvl, out_data.cur_lvl);
                compare_field("percent_q8", 16'(result_want.percent_q8),
                              16'(out_data.percent_q8));
            end
        end
        if (hold_seq != hold_seen)
        begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_seq;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 74;
        set_feature(ddcbf_pkg::FEATURE_RESET);
        test_frames();
        test_reply_path();
        test_random_traffic(110);
        wait_drained();

        send_idle_pct = 74;
        recv_idle_pct = 19;
        set_feature(8'h00);
        test_random_traffic(60);
        wait_drained();
        set_feature(8'hff);
        test_random_traffic(60);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_feature(8'($urandom));
        test_random_traffic(100);
        wait_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
